FILE: hw/rtl/tvd_pkg.sv
// tvd_pkg: shared constants, request and operation codes, controller/datapath
// command and status structs, and the 16-entry palette for the tile video port.
// No dependencies.
package tvd_pkg;

   localparam int VMEM_DEPTH = 16384;
   localparam int ADDR_W     = $clog2(VMEM_DEPTH);
   localparam int BYTE_W     = 8;

   // request modes
   localparam logic [2:0] MODE_RDATA  = 3'd0;
   localparam logic [2:0] MODE_RSTAT  = 3'd1;
   localparam logic [2:0] MODE_WDATA  = 3'd2;
   localparam logic [2:0] MODE_WCTRL  = 3'd3;
   localparam logic [2:0] MODE_VBLANK = 3'd4;
   localparam logic [2:0] MODE_PIXEL  = 3'd5;

   // mode register indexes that hold live bits
   localparam logic [2:0] REG_MODE0    = 3'd0;
   localparam logic [2:0] REG_MODE1    = 3'd1;
   localparam logic [2:0] REG_NAME     = 3'd2;
   localparam logic [2:0] REG_COLOR    = 3'd3;
   localparam logic [2:0] REG_PATTERN  = 3'd4;
   localparam logic [2:0] REG_BACKDROP = 3'd7;

   // datapath operations
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_CLEAR   = 4'd1;
   localparam logic [3:0] OP_RDATA   = 4'd2;
   localparam logic [3:0] OP_RSTAT   = 4'd3;
   localparam logic [3:0] OP_WDATA   = 4'd4;
   localparam logic [3:0] OP_CFIRST  = 4'd5;
   localparam logic [3:0] OP_CREG    = 4'd6;
   localparam logic [3:0] OP_CADDR   = 4'd7;
   localparam logic [3:0] OP_CADDRRD = 4'd8;
   localparam logic [3:0] OP_VBLANK  = 4'd9;
   localparam logic [3:0] OP_FILL    = 4'd10;
   localparam logic [3:0] OP_PNAME   = 4'd11;
   localparam logic [3:0] OP_PCOLOR  = 4'd12;
   localparam logic [3:0] OP_PPAT    = 4'd13;
   localparam logic [3:0] OP_PFINISH = 4'd14;
   localparam logic [3:0] OP_PBLANK  = 4'd15;

   typedef struct packed {
      logic [3:0] op;
      logic       capture;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       second;
      logic       ctl_bit7;
      logic       ctl_bit6;
      logic       blank;
      logic       clear_last;
   } status_type;

   function automatic logic [23:0] palette(input logic [3:0] idx);
      logic [23:0] rgb;
      case (idx)
         4'd0:    rgb = {8'd0,   8'd0,   8'd0};
         4'd1:    rgb = {8'd0,   8'd0,   8'd0};
         4'd2:    rgb = {8'd62,  8'd184, 8'd73};
         4'd3:    rgb = {8'd116, 8'd208, 8'd125};
         4'd4:    rgb = {8'd89,  8'd85,  8'd224};
         4'd5:    rgb = {8'd128, 8'd118, 8'd241};
         4'd6:    rgb = {8'd185, 8'd94,  8'd81};
         4'd7:    rgb = {8'd101, 8'd219, 8'd239};
         4'd8:    rgb = {8'd219, 8'd101, 8'd89};
         4'd9:    rgb = {8'd255, 8'd137, 8'd125};
         4'd10:   rgb = {8'd204, 8'd195, 8'd94};
         4'd11:   rgb = {8'd222, 8'd208, 8'd135};
         4'd12:   rgb = {8'd58,  8'd162, 8'd65};
         4'd13:   rgb = {8'd183, 8'd102, 8'd181};
         4'd14:   rgb = {8'd204, 8'd204, 8'd204};
         default: rgb = {8'd255, 8'd255, 8'd255};
      endcase
      return rgb;
   endfunction

endpackage

FILE: hw/rtl/tvd_ram.sv
// tvd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tvd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/tvd_ctrl.sv
// tvd_ctrl: sequencer for the tile video port; steps each request through
// the datapath and owns the handshakes. Depends on tvd_pkg.
module tvd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tvd_pkg::status_type status,
   output tvd_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_FILL   = 3'd3;
   localparam logic [2:0] S_PCOLOR = 3'd4;
   localparam logic [2:0] S_PPAT   = 3'd5;
   localparam logic [2:0] S_PFIN   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = tvd_pkg::OP_NONE;
      cmd.capture  = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = tvd_pkg::OP_CLEAR;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (status.mode)
               tvd_pkg::MODE_RDATA: begin
                  cmd.op   = tvd_pkg::OP_RDATA;
                  state_in = S_FILL;
               end
               tvd_pkg::MODE_RSTAT:  cmd.op = tvd_pkg::OP_RSTAT;
               tvd_pkg::MODE_WDATA:  cmd.op = tvd_pkg::OP_WDATA;
               tvd_pkg::MODE_WCTRL: begin
                  if (!status.second) begin
                     cmd.op = tvd_pkg::OP_CFIRST;
                  end else if (status.ctl_bit7) begin
                     cmd.op = tvd_pkg::OP_CREG;
                  end else if (status.ctl_bit6) begin
                     cmd.op = tvd_pkg::OP_CADDR;
                  end else begin
                     cmd.op   = tvd_pkg::OP_CADDRRD;
                     state_in = S_FILL;
                  end
               end
               tvd_pkg::MODE_VBLANK: cmd.op = tvd_pkg::OP_VBLANK;
               tvd_pkg::MODE_PIXEL: begin
                  if (status.blank) begin
                     cmd.op = tvd_pkg::OP_PBLANK;
                  end else begin
                     cmd.op   = tvd_pkg::OP_PNAME;
                     state_in = S_PCOLOR;
                  end
               end
               default: cmd.op = tvd_pkg::OP_NONE;
            endcase
         end
         S_FILL: begin
            cmd.op   = tvd_pkg::OP_FILL;
            state_in = S_DONE;
         end
         S_PCOLOR: begin
            cmd.op   = tvd_pkg::OP_PCOLOR;
            state_in = S_PPAT;
         end
         S_PPAT: begin
            cmd.op   = tvd_pkg::OP_PPAT;
            state_in = S_PFIN;
         end
         S_PFIN: begin
            cmd.op   = tvd_pkg::OP_PFINISH;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/tvd_datapath.sv
// tvd_datapath: request latch, access address, read-ahead, mode registers,
// pixel lookup and result register around the video memory.
// Depends on tvd_pkg and tvd_ram.
module tvd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  tvd_pkg::cmd_type    cmd,
   output tvd_pkg::status_type status,
   input  logic [2:0]          req_mode,
   input  logic [7:0]          req_data_byte,
   input  logic                req_vblank_active,
   input  logic [7:0]          req_pixel_x,
   input  logic [7:0]          req_pixel_y,
   output logic [7:0]          rsp_read_data,
   output logic                rsp_interrupt_out,
   output logic [3:0]          rsp_color_index,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue
);

   localparam int AW = tvd_pkg::ADDR_W;

   // latched request
   logic [2:0] mode_ff, mode_in;
   logic [7:0] data_ff, data_in;
   logic       vb_ff, vb_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;

   // port state
   logic [AW-1:0] addr_ff, addr_in;
   logic [7:0]    first_ff, first_in;
   logic          second_ff, second_in;
   logic [7:0]    ahead_ff, ahead_in;
   logic          flag_ff, flag_in;      // status bit 7; bits 6..0 never set
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // live mode register bits; r1 holds bits 5..3
   logic       r0b1_ff, r0b1_in;
   logic [2:0] r1_ff, r1_in;
   logic [3:0] r2_ff, r2_in;
   logic [7:0] r3_ff, r3_in;
   logic [2:0] r4_ff, r4_in;
   logic [3:0] r7_ff, r7_in;

   // pixel lookup and result
   logic [7:0] tile_ff, tile_in;
   logic [7:0] cbyte_ff, cbyte_in;
   logic [7:0] rd_res_ff, rd_res_in;
   logic [3:0] ci_res_ff, ci_res_in;

   logic [7:0]  out_rd_ff;
   logic        out_irq_ff;
   logic [3:0]  out_ci_ff;
   logic [23:0] out_rgb_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [AW-1:0] ctl_addr;
   logic [3:0]    backdrop;
   logic [3:0]    fg, bg;

   tvd_ram #(
      .WIDTH (tvd_pkg::BYTE_W),
      .DEPTH (tvd_pkg::VMEM_DEPTH)
   ) u_vram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ctl_addr = {data_ff[5:0], first_ff};
   assign backdrop = (r7_ff == 4'd0) ? 4'd1 : r7_ff;
   assign fg       = (cbyte_ff[7:4] == 4'd0) ? backdrop : cbyte_ff[7:4];
   assign bg       = (cbyte_ff[3:0] == 4'd0) ? backdrop : cbyte_ff[3:0];

   // memory ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = data_ff;
      rd_addr = addr_ff;
      case (cmd.op)
         tvd_pkg::OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = 8'd0;
         end
         tvd_pkg::OP_WDATA:   wr_en   = 1'b1;
         tvd_pkg::OP_CADDRRD: rd_addr = ctl_addr;
         tvd_pkg::OP_PNAME:   rd_addr = {r2_ff, y_ff[7:3], x_ff[7:3]};
         tvd_pkg::OP_PCOLOR:  rd_addr = {r3_ff, 1'b0, rd_data[7:3]};
         tvd_pkg::OP_PPAT:    rd_addr = {r4_ff, tile_ff, y_ff[2:0]};
         default:             rd_addr = addr_ff;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      data_in    = data_ff;
      vb_in      = vb_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      addr_in    = addr_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      ahead_in   = ahead_ff;
      flag_in    = flag_ff;
      clr_cnt_in = clr_cnt_ff;
      r0b1_in    = r0b1_ff;
      r1_in      = r1_ff;
      r2_in      = r2_ff;
      r3_in      = r3_ff;
      r4_in      = r4_ff;
      r7_in      = r7_ff;
      tile_in    = tile_ff;
      cbyte_in   = cbyte_ff;
      rd_res_in  = rd_res_ff;
      ci_res_in  = ci_res_ff;

      if (cmd.capture) begin
         mode_in   = req_mode;
         data_in   = req_data_byte;
         vb_in     = req_vblank_active;
         x_in      = req_pixel_x;
         y_in      = req_pixel_y;
         rd_res_in = 8'd0;
         ci_res_in = 4'd0;
      end

      case (cmd.op)
         tvd_pkg::OP_CLEAR: clr_cnt_in = clr_cnt_ff + AW'(1);
         tvd_pkg::OP_RDATA: begin
            rd_res_in = ahead_ff;
            second_in = 1'b0;
         end
         tvd_pkg::OP_RSTAT: begin
            rd_res_in = {flag_ff, 7'd0};
            flag_in   = 1'b0;
            second_in = 1'b0;
         end
         tvd_pkg::OP_WDATA: begin
            addr_in   = addr_ff + AW'(1);
            second_in = 1'b0;
         end
         tvd_pkg::OP_CFIRST: begin
            first_in  = data_ff;
            second_in = 1'b1;
         end
         tvd_pkg::OP_CREG: begin
            second_in = 1'b0;
            case (data_ff[2:0])
               tvd_pkg::REG_MODE0:    r0b1_in = first_ff[1];
               tvd_pkg::REG_MODE1:    r1_in   = first_ff[5:3];
               tvd_pkg::REG_NAME:     r2_in   = first_ff[3:0];
               tvd_pkg::REG_COLOR:    r3_in   = first_ff;
               tvd_pkg::REG_PATTERN:  r4_in   = first_ff[2:0];
               tvd_pkg::REG_BACKDROP: r7_in   = first_ff[3:0];
               default:               r7_in   = r7_ff;
            endcase
         end
         tvd_pkg::OP_CADDR, tvd_pkg::OP_CADDRRD: begin
            second_in = 1'b0;
            addr_in   = ctl_addr;
         end
         tvd_pkg::OP_VBLANK: flag_in = vb_ff;
         tvd_pkg::OP_FILL: begin
            ahead_in = rd_data;
            addr_in  = addr_ff + AW'(1);
         end
         tvd_pkg::OP_PCOLOR:  tile_in  = rd_data;
         tvd_pkg::OP_PPAT:    cbyte_in = rd_data;
         tvd_pkg::OP_PFINISH: ci_res_in = rd_data[~x_ff[2:0]] ? fg : bg;
         tvd_pkg::OP_PBLANK:  ci_res_in = backdrop;
         default:             ci_res_in = ci_res_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         first_ff   <= 8'd0;
         second_ff  <= 1'b0;
         ahead_ff   <= 8'd0;
         flag_ff    <= 1'b0;
         clr_cnt_ff <= '0;
         r0b1_ff    <= 1'b0;
         r1_ff      <= 3'd0;
         r2_ff      <= 4'd0;
         r3_ff      <= 8'd0;
         r4_ff      <= 3'd0;
         r7_ff      <= 4'd0;
      end else begin
         addr_ff    <= addr_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         ahead_ff   <= ahead_in;
         flag_ff    <= flag_in;
         clr_cnt_ff <= clr_cnt_in;
         r0b1_ff    <= r0b1_in;
         r1_ff      <= r1_in;
         r2_ff      <= r2_in;
         r3_ff      <= r3_in;
         r4_ff      <= r4_in;
         r7_ff      <= r7_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      data_ff   <= data_in;
      vb_ff     <= vb_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      tile_ff   <= tile_in;
      cbyte_ff  <= cbyte_in;
      rd_res_ff <= rd_res_in;
      ci_res_ff <= ci_res_in;
      if (cmd.load_out) begin
         out_rd_ff  <= rd_res_ff;
         out_irq_ff <= flag_ff && r1_ff[2];
         out_ci_ff  <= ci_res_ff;
         out_rgb_ff <= (mode_ff == tvd_pkg::MODE_PIXEL) ?
                       tvd_pkg::palette(ci_res_ff) : 24'd0;
      end
   end

   assign status.mode       = mode_ff;
   assign status.second     = second_ff;
   assign status.ctl_bit7   = data_ff[7];
   assign status.ctl_bit6   = data_ff[6];
   assign status.blank      = r1_ff[1] || r1_ff[0] || r0b1_ff;
   assign status.clear_last = (clr_cnt_ff == {AW{1'b1}});

   assign rsp_read_data     = out_rd_ff;
   assign rsp_interrupt_out = out_irq_ff;
   assign rsp_color_index   = out_ci_ff;
   assign rsp_red           = out_rgb_ff[23:16];
   assign rsp_green         = out_rgb_ff[15:8];
   assign rsp_blue          = out_rgb_ff[7:0];

endmodule

FILE: hw/rtl/tile_video_display_port.sv
// tile_video_display_port: top level of the tile video display port.
// Joins the tvd_ctrl sequencer and the tvd_datapath; depends on tvd_pkg.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   mode, data_byte, vblank_active,
//                                             pixel_x, pixel_y
//   rsp      out        rsp_valid/rsp_stall   read_data, interrupt_out,
//                                             color_index, red, green, blue
//
// One request at a time. Status read, data write, control byte and vblank
// update pass through the execute and done states; data read and read-setup
// control add a fill state (the prefetch waits on the registered read of the
// video memory), and a pixel adds colour, pattern and finish states (name,
// colour and pattern reads chained through the one read port). Blanked
// pixels take the short path through execute and done.
// After reset a clearing pass zeroes the video memory one byte a cycle,
// with req_stall held high.
// A result sits in the output register until transferred; a stalled rsp
// side holds the finished item and the next request waits behind it.
module tile_video_display_port (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_data_byte,
   input  logic       req_vblank_active,
   input  logic [7:0] req_pixel_x,
   input  logic [7:0] req_pixel_y,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_interrupt_out,
   output logic [3:0] rsp_color_index,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);

   // command and status between sequencer and datapath
   tvd_pkg::cmd_type    cmd;
   tvd_pkg::status_type status;

   tvd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tvd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_data_byte     (req_data_byte),
      .req_vblank_active (req_vblank_active),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_read_data     (rsp_read_data),
      .rsp_interrupt_out (rsp_interrupt_out),
      .rsp_color_index   (rsp_color_index),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue)
   );

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking bench for the tile video display port.
// Drives request transfers, predicts each response from a shadow copy of the
// port state and compares field by field; needs tvd_pkg and the RTL only.
module tb_top;

   localparam int CLK_PERIOD   = 4;
   localparam int LIMIT_CYCLES = 250000;   // clearing pass plus a slow run, several times over
   localparam int ITEM_TARGET  = 650;
   localparam int CALM_FROM    = 560;      // no idling on either side from here on
   localparam int DRAIN_EVERY  = 200;
   localparam int TAIL_CYCLES  = 16;

   // modes with no function; they still return a result
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;

   typedef struct packed {
      logic [7:0] read_data;
      logic       interrupt_out;
      logic [3:0] color_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } port_reply_type;

   typedef struct {
      logic [2:0]     mode;
      logic [7:0]     data;
      logic           vb;
      logic [7:0]     x;
      logic [7:0]     y;
      bit             typed;
      port_reply_type want;
   } stim_row_type;

   // replies that can be read straight off the reset state
   localparam port_reply_type QUIET     = '0;
   localparam port_reply_type BACKDROP1 = {8'h00, 1'b0, 4'd1, 24'd0};
   localparam port_reply_type VBL_SEEN  = {8'h80, 1'b0, 4'd0, 24'd0};
   localparam port_reply_type IRQ_ONLY  = {8'h00, 1'b1, 4'd0, 24'd0};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_mode = tvd_pkg::MODE_RDATA;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_vblank_active = 1'b0;
   logic [7:0] req_pixel_x = 8'h00;
   logic [7:0] req_pixel_y = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_interrupt_out;
   logic [3:0] rsp_color_index;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;

   always #(CLK_PERIOD / 2) clock = ~clock;

   tile_video_display_port uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_data_byte     (req_data_byte),
      .req_vblank_active (req_vblank_active),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_interrupt_out (rsp_interrupt_out),
      .rsp_color_index   (rsp_color_index),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue)
   );

   // ---------------------------------------------------------------------------
   // Shadow of the port state, advanced once per accepted request transfer
   // ---------------------------------------------------------------------------
   logic [7:0]  shadow_vram [0:16383];
   logic [7:0]  shadow_regs [0:7];
   logic [7:0]  shadow_status;
   logic [13:0] vram_ptr;
   logic [7:0]  latched_ctrl;
   logic        ctrl_pending;   // first control byte seen, second awaited
   logic [7:0]  read_ahead;

   port_reply_type replies_due [$];
   stim_row_type   opening [$];

   int unsigned mismatches = 0;
   int unsigned replies_checked = 0;
   int unsigned accepted = 0;       // requests that do something
   int unsigned mode_count [8];
   int unsigned blanked_pixels = 0;
   int unsigned gap_pct = 0;
   bit          calm = 1'b0;

   function automatic logic [23:0] rgb_of(input logic [3:0] shade);
      case (shade)
         4'd0, 4'd1: return {8'd0, 8'd0, 8'd0};
         4'd2:  return {8'd62, 8'd184, 8'd73};
         4'd3:  return {8'd116, 8'd208, 8'd125};
         4'd4:  return {8'd89, 8'd85, 8'd224};
         4'd5:  return {8'd128, 8'd118, 8'd241};
         4'd6:  return {8'd185, 8'd94, 8'd81};
         4'd7:  return {8'd101, 8'd219, 8'd239};
         4'd8:  return {8'd219, 8'd101, 8'd89};
         4'd9:  return {8'd255, 8'd137, 8'd125};
         4'd10: return {8'd204, 8'd195, 8'd94};
         4'd11: return {8'd222, 8'd208, 8'd135};
         4'd12: return {8'd58, 8'd162, 8'd65};
         4'd13: return {8'd183, 8'd102, 8'd181};
         4'd14: return {8'd204, 8'd204, 8'd204};
         default: return {8'd255, 8'd255, 8'd255};
      endcase
   endfunction

   // Graphics I lookup: name entry -> colour byte (one per 8 tiles) -> pattern row.
   // All table addresses wrap at 16 KiB; rows past the screen use the same sums.
   function automatic logic [3:0] pixel_shade(input logic [7:0] x, input logic [7:0] y);
      logic [3:0]  backdrop;
      logic [3:0]  fg;
      logic [3:0]  bg;
      logic [13:0] name_at;
      logic [13:0] colour_at;
      logic [13:0] pattern_at;
      logic [7:0]  tile;
      logic [7:0]  colours;
      logic [7:0]  bits;
      backdrop = shadow_regs[tvd_pkg::REG_BACKDROP][3:0];
      if (backdrop == 4'd0) backdrop = 4'd1;
      if (shadow_regs[tvd_pkg::REG_MODE1][4] || shadow_regs[tvd_pkg::REG_MODE1][3] ||
          shadow_regs[tvd_pkg::REG_MODE0][1]) begin
         blanked_pixels++;
         return backdrop;
      end
      name_at = {shadow_regs[tvd_pkg::REG_NAME][3:0], 10'd0} + {4'd0, y[7:3], x[7:3]};
      tile = shadow_vram[name_at];
      colour_at = {shadow_regs[tvd_pkg::REG_COLOR], 6'd0} + {9'd0, tile[7:3]};
      colours = shadow_vram[colour_at];
      fg = (colours[7:4] == 4'd0) ? backdrop : colours[7:4];
      bg = (colours[3:0] == 4'd0) ? backdrop : colours[3:0];
      pattern_at = {shadow_regs[tvd_pkg::REG_PATTERN][2:0], 11'd0} +
                   {3'd0, tile, y[2:0]};
      bits = shadow_vram[pattern_at];
      return bits[3'd7 - x[2:0]] ? fg : bg;
   endfunction

   function automatic port_reply_type display_port_access(input logic [2:0] mode,
                                                          input logic [7:0] data,
                                                          input logic vb,
                                                          input logic [7:0] x,
                                                          input logic [7:0] y);
      port_reply_type rep;
      logic [23:0]    rgb;
      rep = '0;
      case (mode)
         tvd_pkg::MODE_RDATA: begin
            ctrl_pending = 1'b0;
            rep.read_data = read_ahead;
            read_ahead = shadow_vram[vram_ptr];
            vram_ptr = vram_ptr + 14'd1;
         end
         tvd_pkg::MODE_RSTAT: begin
            ctrl_pending = 1'b0;
            rep.read_data = shadow_status;
            shadow_status[7:5] = 3'b000;
         end
         tvd_pkg::MODE_WDATA: begin
            ctrl_pending = 1'b0;
            shadow_vram[vram_ptr] = data;
            vram_ptr = vram_ptr + 14'd1;
         end
         tvd_pkg::MODE_WCTRL: begin
            if (!ctrl_pending) begin
               latched_ctrl = data;
               ctrl_pending = 1'b1;
            end else begin
               ctrl_pending = 1'b0;
               if (data[7]) begin
                  // register load: index in the low three bits
                  shadow_regs[data[2:0]] = latched_ctrl;
               end else begin
                  vram_ptr = {data[5:0], latched_ctrl};
                  if (!data[6]) begin
                     // read setup fetches one byte ahead
                     read_ahead = shadow_vram[vram_ptr];
                     vram_ptr = vram_ptr + 14'd1;
                  end
               end
            end
         end
         tvd_pkg::MODE_VBLANK: shadow_status[7] = vb;
         tvd_pkg::MODE_PIXEL: begin
            rep.color_index = pixel_shade(x, y);
            rgb = rgb_of(rep.color_index);
            {rep.red, rep.green, rep.blue} = rgb;
         end
         default: ;
      endcase
      rep.interrupt_out = shadow_status[7] & shadow_regs[tvd_pkg::REG_MODE1][5];
      return rep;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   task automatic flag_mismatch(input string note);
      mismatches++;
      $display("%0t  MISMATCH  %s", $time, note);
   endtask

   // Hold one request until its transfer, then record what it should return.
   // A random gap may follow; valid is never dropped and raised in one step.
   task automatic offer_request(input logic [2:0] mode, input logic [7:0] data,
                                input logic vb, input logic [7:0] x, input logic [7:0] y,
                                input bit typed, input port_reply_type want);
      port_reply_type due;
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_data_byte     <= data;
      req_vblank_active <= vb;
      req_pixel_x       <= x;
      req_pixel_y       <= y;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      due = display_port_access(mode, data, vb, x, y);
      replies_due.push_back(typed ? want : due);
      mode_count[mode]++;
      if (mode <= tvd_pkg::MODE_PIXEL) accepted++;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // unused fields carry random values so every input bit toggles
   task automatic offer_mode(input logic [2:0] mode, input logic [7:0] data);
      offer_request(mode, data, 1'($urandom), 8'($urandom), 8'($urandom), 1'b0, QUIET);
   endtask

   // well-formed two-byte control write; a dangling first byte is flushed
   // by a status read so the pair lines up
   task automatic ctrl_pair(input logic [7:0] first, input logic [7:0] second);
      if (ctrl_pending) offer_mode(tvd_pkg::MODE_RSTAT, 8'($urandom));
      offer_mode(tvd_pkg::MODE_WCTRL, first);
      offer_mode(tvd_pkg::MODE_WCTRL, second);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // addresses aimed mostly at the live name, colour and pattern tables
   function automatic logic [13:0] pick_vram_target();
      case ($urandom_range(0, 3))
         0: return {shadow_regs[tvd_pkg::REG_NAME][3:0], 10'd0} +
                   14'($urandom_range(0, 767));
         1: return {shadow_regs[tvd_pkg::REG_COLOR], 6'd0} + 14'($urandom_range(0, 31));
         2: return {shadow_regs[tvd_pkg::REG_PATTERN][2:0], 11'd0} +
                   14'($urandom_range(0, 2047));
         default: return 14'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int unsigned kind;
      int unsigned next_drain;
      logic [2:0]  slot;
      logic [7:0]  value;
      logic [13:0] point;

      foreach (shadow_vram[i]) shadow_vram[i] = 8'h00;
      foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
      foreach (mode_count[i]) mode_count[i] = 0;
      shadow_status = 8'h00;
      vram_ptr      = '0;
      latched_ctrl  = 8'h00;
      ctrl_pending  = 1'b0;
      read_ahead    = 8'h00;

      // Directed opening: reset state, field extremes, every mode and the
      // corner cases. Typed replies where obvious; the rest predicted.
      opening.push_back('{tvd_pkg::MODE_RSTAT, 8'h00, 1'b0, 8'd0, 8'd0, 1'b1, QUIET});
      opening.push_back('{tvd_pkg::MODE_RDATA, 8'hff, 1'b1, 8'd255, 8'd191, 1'b1, QUIET});
      // cleared memory, backdrop 0 promoted to 1
      opening.push_back('{tvd_pkg::MODE_PIXEL, 8'h00, 1'b0, 8'd0, 8'd0, 1'b1, BACKDROP1});
      opening.push_back('{tvd_pkg::MODE_PIXEL, 8'hff, 1'b1, 8'd255, 8'd191, 1'b1,
                          BACKDROP1});
      // vblank raised while interrupts are still masked
      opening.push_back('{tvd_pkg::MODE_VBLANK, 8'h00, 1'b1, 8'd0, 8'd0, 1'b1, QUIET});
      opening.push_back('{tvd_pkg::MODE_RSTAT, 8'h00, 1'b0, 8'd0, 8'd0, 1'b1, VBL_SEEN});
      opening.push_back('{tvd_pkg::MODE_RSTAT, 8'h00, 1'b0, 8'd0, 8'd0, 1'b1, QUIET});
      // interrupt enable into mode register 1
      opening.push_back('{tvd_pkg::MODE_WCTRL, 8'h20, 1'b0, 8'd0, 8'd0, 1'b1, QUIET});
      opening.push_back('{tvd_pkg::MODE_WCTRL, {5'b10000, tvd_pkg::REG_MODE1}, 1'b0,
                          8'd0, 8'd0, 1'b1, QUIET});
      opening.push_back('{tvd_pkg::MODE_VBLANK, 8'h00, 1'b1, 8'd0, 8'd0, 1'b1, IRQ_ONLY});
      opening.push_back('{tvd_pkg::MODE_VBLANK, 8'hff, 1'b0, 8'd0, 8'd0, 1'b1, QUIET});
      // write setup at the top address; second write wraps to zero
      opening.push_back('{tvd_pkg::MODE_WCTRL, 8'hff, 1'b0, 8'd0, 8'd0, 1'b0, QUIET});
      opening.push_back('{tvd_pkg::MODE_WCTRL, 8'h7f, 1'b0, 8'd0, 8'd0, 1'b0, QUIET});
      opening.push_back('{tvd_pkg::MODE_WDATA, 8'hff, 1'b0, 8'd0, 8'd0, 1'b0, QUIET});
      opening.push_back('{tvd_pkg::MODE_WDATA, 8'h00, 1'b1, 8'd0, 8'd0, 1'b0, QUIET});
      // read setup at the top address, prefetch then read back
      opening.push_back('{tvd_pkg::MODE_WCTRL, 8'hff, 1'b0, 8'd0, 8'd0, 1'b0, QUIET});
      opening.push_back('{tvd_pkg::MODE_WCTRL, 8'h3f, 1'b0, 8'd0, 8'd0, 1'b0, QUIET});
      opening.push_back('{tvd_pkg::MODE_RDATA, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, QUIET});
      // spare mode between the control bytes must not break the pair
      opening.push_back('{tvd_pkg::MODE_WCTRL, 8'h0e, 1'b0, 8'd0, 8'd0, 1'b0, QUIET});
      opening.push_back('{MODE_SPARE6, 8'hff, 1'b1, 8'd255, 8'd255, 1'b0, QUIET});
      opening.push_back('{tvd_pkg::MODE_WCTRL, {5'b10000, tvd_pkg::REG_BACKDROP}, 1'b0,
                          8'd0, 8'd0, 1'b0, QUIET});
      opening.push_back('{MODE_SPARE7, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, QUIET});
      // row past the bottom of the screen
      opening.push_back('{tvd_pkg::MODE_PIXEL, 8'h00, 1'b0, 8'h80, 8'hff, 1'b0, QUIET});
      // blanking via mode register 1 gives the backdrop only
      opening.push_back('{tvd_pkg::MODE_WCTRL, 8'h18, 1'b0, 8'd0, 8'd0, 1'b0, QUIET});
      opening.push_back('{tvd_pkg::MODE_WCTRL, {5'b10000, tvd_pkg::REG_MODE1}, 1'b0,
                          8'd0, 8'd0, 1'b0, QUIET});
      opening.push_back('{tvd_pkg::MODE_PIXEL, 8'h00, 1'b0, 8'h7f, 8'h00, 1'b0, QUIET});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // the clearing pass holds req_stall; the first transfer simply waits for it
      gap_pct = 30;
      foreach (opening[i])
         offer_request(opening[i].mode, opening[i].data, opening[i].vb, opening[i].x,
                       opening[i].y, opening[i].typed, opening[i].want);
      drain_replies();

      // Random part: mostly well-formed episodes with random content, some noise.
      next_drain = DRAIN_EVERY;
      while (accepted < ITEM_TARGET) begin
         calm = (accepted >= CALM_FROM);
         if (accepted >= next_drain) begin
            drain_replies();
            next_drain += DRAIN_EVERY;
         end
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 20;
            default: gap_pct = 50;
         endcase
         kind = $urandom_range(0, 99);
         if (kind < 18) begin
            // mode register load; blanking bits kept clear most of the time
            slot  = ($urandom_range(0, 2) == 0) ? tvd_pkg::REG_MODE1
                                                : 3'($urandom_range(0, 7));
            value = 8'($urandom);
            if (slot == tvd_pkg::REG_MODE1 && $urandom_range(0, 3) != 0) value[4:3] = 2'b00;
            if (slot == tvd_pkg::REG_MODE0 && $urandom_range(0, 3) != 0) value[1] = 1'b0;
            ctrl_pair(value, {1'b1, 4'($urandom), slot});
         end else if (kind < 38) begin
            point = pick_vram_target();
            ctrl_pair(point[7:0], {2'b01, point[13:8]});
            repeat ($urandom_range(1, 8)) offer_mode(tvd_pkg::MODE_WDATA, 8'($urandom));
         end else if (kind < 48) begin
            // mostly read setup; now and then a write setup read back anyway
            point = pick_vram_target();
            ctrl_pair(point[7:0], {1'b0, 1'($urandom_range(0, 4) == 0), point[13:8]});
            repeat ($urandom_range(1, 6)) offer_mode(tvd_pkg::MODE_RDATA, 8'($urandom));
         end else if (kind < 73) begin
            repeat ($urandom_range(1, 10))
               offer_request(tvd_pkg::MODE_PIXEL, 8'($urandom), 1'($urandom), 8'($urandom),
                             ($urandom_range(0, 7) == 0) ? 8'($urandom_range(192, 255))
                                                         : 8'($urandom_range(0, 191)),
                             1'b0, QUIET);
         end else if (kind < 83) begin
            offer_request(tvd_pkg::MODE_VBLANK, 8'($urandom), 1'($urandom), 8'($urandom),
                          8'($urandom), 1'b0, QUIET);
            if ($urandom_range(0, 1) == 0) offer_mode(tvd_pkg::MODE_RSTAT, 8'($urandom));
         end else begin
            // noise: any mode, any fields, broken control pairs included
            repeat ($urandom_range(1, 4))
               offer_request(3'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                             8'($urandom), 1'b0, QUIET);
         end
      end

      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests: reads %0d, status %0d, writes %0d, control %0d",
               accepted, mode_count[tvd_pkg::MODE_RDATA], mode_count[tvd_pkg::MODE_RSTAT],
               mode_count[tvd_pkg::MODE_WDATA], mode_count[tvd_pkg::MODE_WCTRL]);
      $display("  vblank %0d, pixels %0d (%0d blanked), spare %0d; %0d checked, %0d bad",
               mode_count[tvd_pkg::MODE_VBLANK], mode_count[tvd_pkg::MODE_PIXEL],
               blanked_pixels, mode_count[MODE_SPARE6] + mode_count[MODE_SPARE7],
               replies_checked, mismatches);
      if (mismatches == 0) begin
         $display("[tile_video_display_port] OK");
      end else begin
         $display("[tile_video_display_port] ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Response side: random stall bursts, quiet stretches, none once calm
   // ---------------------------------------------------------------------------
   initial begin : rsp_pacing
      while (1) begin
         if (calm || $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(8, 40)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 5)) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 7)) @(posedge clock);
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
      end
   end

   // each response transfer is matched against the oldest outstanding reply
   always @(posedge clock) begin : rsp_check
      port_reply_type got;
      port_reply_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got = {rsp_read_data, rsp_interrupt_out, rsp_color_index, rsp_red, rsp_green,
                rsp_blue};
         if (replies_due.size() == 0) begin
            flag_mismatch($sformatf("response with nothing outstanding: %h", got));
         end else begin
            due = replies_due.pop_front();
            replies_checked++;
            if (got.read_data !== due.read_data)
               flag_mismatch($sformatf("read_data %h, predicted %h",
                                       got.read_data, due.read_data));
            if (got.interrupt_out !== due.interrupt_out)
               flag_mismatch($sformatf("interrupt_out %b, predicted %b",
                                       got.interrupt_out, due.interrupt_out));
            if (got.color_index !== due.color_index)
               flag_mismatch($sformatf("color_index %h, predicted %h",
                                       got.color_index, due.color_index));
            if (got.red !== due.red)
               flag_mismatch($sformatf("red %h, predicted %h", got.red, due.red));
            if (got.green !== due.green)
               flag_mismatch($sformatf("green %h, predicted %h", got.green, due.green));
            if (got.blue !== due.blue)
               flag_mismatch($sformatf("blue %h, predicted %h", got.blue, due.blue));
         end
      end
   end

   // watchdog
   initial begin : run_limit
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("[tile_video_display_port] ERROR");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/tvd_pkg.sv
hw/rtl/tvd_ram.sv
hw/rtl/tvd_ctrl.sv
hw/rtl/tvd_datapath.sv
hw/rtl/tile_video_display_port.sv
verif/tb_top.sv
